### sv/blc_pkg.sv
// Shared constants and command/status types for the binary linear complexity block.
package blc_pkg;

	// Default window length in sequence bits.
	localparam int WINDOW_BITS_DEF = 512;

	// Result field width and its saturation value.
	localparam int               LC_W   = 10;
	localparam logic [LC_W-1:0]  LC_MAX = 10'd1023;

	// Input byte width and bits per byte.
	localparam int BYTE_W = 8;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;   // take a new byte into the bit shifter
		logic step;   // run one Berlekamp-Massey step on the leading bit
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic last;   // next step completes the window
	} sts_t;

endpackage

### sv/blc_datapath.sv
// Berlekamp-Massey datapath: sequence, connection and prior polynomials, L and bit count.
module blc_datapath #(
	parameter int WINDOW_BITS = blc_pkg::WINDOW_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  blc_pkg::cmd_t                cmd,
	input  logic [blc_pkg::BYTE_W-1:0]   byte_in,
	output blc_pkg::sts_t                sts,
	output logic [blc_pkg::LC_W-1:0]     lc_out
);

	localparam int PW = $clog2(WINDOW_BITS);
	localparam int LW = $clog2(WINDOW_BITS + 1);

	logic [WINDOW_BITS-1:0]      seq_q, conn_q, sp_q;
	logic [LW-1:0]               l_q;
	logic [PW-1:0]               pos_q;
	logic [blc_pkg::BYTE_W-1:0]  byte_q;
	logic [blc_pkg::LC_W-1:0]    lc_q;

	logic [WINDOW_BITS-1:0]      seq_nx, conn_nx, sp_base, sp_nx;
	logic [LW-1:0]               l_nx;
	logic [LW:0]                 two_l, n_ext;
	logic                        disc, swap, last;
	logic [blc_pkg::LC_W-1:0]    lc_sat;

	assign last = (pos_q == PW'(WINDOW_BITS - 1));

	always_comb begin
		// coefficient k at bit k; times x is a left shift that drops the top
		seq_nx  = {seq_q[WINDOW_BITS-2:0], byte_q[blc_pkg::BYTE_W-1]};
		disc    = ^(conn_q & seq_nx);
		two_l   = {l_q, 1'b0};
		n_ext   = (LW+1)'(pos_q);
		swap    = disc && (two_l <= n_ext);
		conn_nx = disc ? (conn_q ^ sp_q) : conn_q;
		sp_base = swap ? conn_q : sp_q;
		sp_nx   = {sp_base[WINDOW_BITS-2:0], 1'b0};
		l_nx    = swap ? LW'(LW'(pos_q) + LW'(1) - l_q) : l_q;
		if (32'(l_nx) > 32'(blc_pkg::LC_MAX)) begin
			lc_sat = blc_pkg::LC_MAX;
		end else begin
			lc_sat = blc_pkg::LC_W'(l_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= '0;
			conn_q <= WINDOW_BITS'(1);
			sp_q   <= WINDOW_BITS'(2);
			l_q    <= '0;
			pos_q  <= '0;
		end else if (cmd.step) begin
			if (last) begin
				seq_q  <= '0;
				conn_q <= WINDOW_BITS'(1);
				sp_q   <= WINDOW_BITS'(2);
				l_q    <= '0;
				pos_q  <= '0;
			end else begin
				seq_q  <= seq_nx;
				conn_q <= conn_nx;
				sp_q   <= sp_nx;
				l_q    <= l_nx;
				pos_q  <= pos_q + PW'(1);
			end
		end
	end

	// payload registers: byte shifter and result word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= byte_in;
		end else if (cmd.step) begin
			byte_q <= {byte_q[blc_pkg::BYTE_W-2:0], 1'b0};
		end
		if (cmd.step && last) begin
			lc_q <= lc_sat;
		end
	end

	assign sts.last = last;
	assign lc_out   = lc_q;

endmodule

### sv/blc_ctrl.sv
// Controller: byte intake, eight-step sequencing and result word handshake.
module blc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  blc_pkg::sts_t  sts,
	output blc_pkg::cmd_t  cmd
);

	typedef enum logic {IDLE, RUN} state_t;

	state_t      state_q;
	logic [2:0]  cnt_q;
	logic        out_valid_q;
	logic        can_step;
	logic        load;

	// a window-ending step waits while the result word is still held
	assign can_step = (state_q == RUN) && !(sts.last && out_valid_q && !m_tready);
	assign s_tready = (state_q == IDLE) || (cnt_q == 3'd7 && can_step);
	assign load     = s_tvalid && s_tready;
	assign cmd.load = load;
	assign cmd.step = can_step;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (can_step && sts.last) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (load) begin
						state_q <= RUN;
						cnt_q   <= '0;
					end
				end
				RUN: begin
					if (can_step) begin
						cnt_q <= cnt_q + 3'd1;
						if (cnt_q == 3'd7 && !load) begin
							state_q <= IDLE;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && sts.last |-> !(out_valid_q && !m_tready))
		else $error("result word overwritten while stalled");
	a_load_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == IDLE || cnt_q == 3'd7))
		else $error("byte loaded mid-byte");
	a_hold_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == RUN && !cmd.step |=> $stable(cnt_q))
		else $error("bit count moved without a step");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && sts.last |=> out_valid_q)
		else $error("completed window not presented");
`endif

endmodule

### sv/binary_linear_complexity_top.sv
// Top level of the binary linear complexity block (Berlekamp-Massey over GF(2)).
//
// Input channel s_*: one word per byte; bit 7 is the earliest sequence bit.
// Output channel m_*: one word per completed window of WINDOW_BITS bits,
// carrying the shortest LFSR length L, saturated at 1023.
// The datapath runs one Berlekamp-Massey step per cycle, unless a stall
// holds it, over WINDOW_BITS-wide polynomial registers; the parity of
// the connection/sequence product decides whether the connection
// polynomial is updated. The next byte is taken in the cycle of the
// eighth step, so back-to-back bytes flow with no gap between them.
// The result word appears in the cycle after the step that ends the
// window and is held in an output register; bytes keep flowing while it
// waits. Only the step that would end the next window stalls until the
// word is taken.
// Reset (arst_n low) clears the window: L = 0, connection polynomial 1,
// prior polynomial x, no result pending.
module binary_linear_complexity_top #(
	parameter int WINDOW_BITS = blc_pkg::WINDOW_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [9:0] linear_complexity, [15:10] zero
);

	blc_pkg::cmd_t                 cmd;
	blc_pkg::sts_t                 sts;
	logic [blc_pkg::LC_W-1:0]      lc;

	blc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	blc_datapath #(
		.WINDOW_BITS (WINDOW_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.byte_in (s_tdata),
		.sts     (sts),
		.lc_out  (lc)
	);

	assign m_tdata = {6'b0, lc};

endmodule
